>>> hdl/calendar_date_stepper_core_defines.svh
`ifndef CALENDAR_DATE_STEPPER_CORE_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDS_ASSERT(lbl, clk, rst, prop, msg)
`define CDS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/cds_pkg.sv
package cds_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BACK = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int YEAR_CYCLE   = 400;
  localparam int CENTURY      = 100;
  localparam int LEAP_FEB     = 29;
  localparam int MONTHS       = 12;
  localparam int LAST_DAY_DEC = 31;

  localparam logic [4:0] MONTH_LEN [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
    logic [15:0] step_count;
  } cds_request_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
  } cds_result_t;

  typedef struct packed {
    logic load;
    logic fwd;
    logic back;
  } cds_date_ctrl_t;

  // leap test from year mod 400
  function automatic logic leap_from_mod(input logic [8:0] r);
    logic by4;
    logic cent;
    by4  = (r[1:0] == 2'd0);
    cent = (r == 9'(CENTURY)) || (r == 9'(2 * CENTURY)) || (r == 9'(3 * CENTURY));
    return (by4 && !cent) || (r == 9'd0);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m > 4'(MONTHS)) begin
      len = 5'd0;
    end else if (m == 4'd2 && leap) begin
      len = 5'(LEAP_FEB);
    end else begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

>>> hdl/cds_rem400.sv
module cds_rem400 #(
  parameter int YEAR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [YEAR_BITS-1:0] value,
  output logic                 done,
  output logic [8:0]           rem
);
  import cds_pkg::*;

  localparam int LOW_BITS = 4;
  localparam int ODD_DIV  = YEAR_CYCLE / (1 << LOW_BITS);
  localparam int XW       = YEAR_BITS - LOW_BITS;
  localparam int MW       = XW + 1;
  localparam int SHIFT    = XW + $clog2(ODD_DIV);
  localparam int PW       = XW + MW;
  localparam int QW       = PW - SHIFT;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(ODD_DIV - 1)) / 64'(ODD_DIV);

  logic [YEAR_BITS-1:0] y;
  logic [PW-1:0]        prod;
  logic                 stage1;
  logic                 stage2;
  logic [QW-1:0]        quot;
  logic [XW-1:0]        resid;

  // year mod 400 = 16 * ((year >> 4) mod 25) + low four bits
  assign quot  = prod[PW-1:SHIFT];
  assign resid = y[YEAR_BITS-1:LOW_BITS] - XW'(quot) * XW'(ODD_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y <= value;
    end
    if (stage1) begin
      prod <= PW'(y[YEAR_BITS-1:LOW_BITS]) * PW'(MW'(RECIP));
    end
    if (stage2) begin
      rem <= {resid[4:0], y[LOW_BITS-1:0]};
    end
  end

endmodule

>>> hdl/cds_date_unit.sv
module cds_date_unit #(
  parameter int YEAR_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cds_pkg::cds_date_ctrl_t ctrl,
  input  logic [4:0]              ld_day,
  input  logic [3:0]              ld_month,
  input  logic [YEAR_BITS-1:0]    ld_year,
  input  logic [8:0]              ld_mod,
  output logic [4:0]              day,
  output logic [3:0]              month,
  output logic [YEAR_BITS-1:0]    year
);
  import cds_pkg::*;

  localparam longint unsigned YEAR_MAX = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [8:0] WRAP_MOD = 9'(YEAR_MAX % 64'(YEAR_CYCLE));
  localparam logic [8:0] MOD_LAST = 9'(YEAR_CYCLE - 1);

  logic [8:0] ymod;
  logic       leap;
  logic [4:0] len_cur;
  logic [4:0] len_prev;
  logic [4:0] len_ld;
  logic       ld_ok;

  assign leap     = leap_from_mod(ymod);
  assign len_cur  = days_in(month, leap);
  assign len_prev = days_in(month - 4'd1, leap);
  assign len_ld   = days_in(ld_month, leap_from_mod(ld_mod));
  assign ld_ok    = (ld_month >= 4'd1) && (ld_month <= 4'(MONTHS));

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= '0;
      month <= '0;
      year  <= '0;
      ymod  <= '0;
    end else if (ctrl.load) begin
      year <= ld_year;
      ymod <= ld_mod;
      if (ld_ok) begin
        month <= ld_month;
        day   <= (ld_day <= len_ld) ? ld_day : 5'd0;
      end else begin
        month <= 4'd0;
        day   <= 5'd0;
      end
    end else if (ctrl.fwd) begin
      if (day < len_cur) begin
        day <= day + 5'd1;
      end else if (month < 4'(MONTHS)) begin
        day   <= 5'd1;
        month <= month + 4'd1;
      end else begin
        day   <= 5'd1;
        month <= 4'd1;
        year  <= year + YEAR_BITS'(1);
        if (year == '1) begin
          ymod <= 9'd0;
        end else begin
          ymod <= (ymod == MOD_LAST) ? 9'd0 : ymod + 9'd1;
        end
      end
    end else if (ctrl.back) begin
      if (day > 5'd1) begin
        day <= day - 5'd1;
      end else if (month > 4'd1) begin
        month <= month - 4'd1;
        day   <= len_prev;
      end else begin
        month <= 4'(MONTHS);
        day   <= 5'(LAST_DAY_DEC);
        year  <= year - YEAR_BITS'(1);
        if (year == '0) begin
          ymod <= WRAP_MOD;
        end else begin
          ymod <= (ymod == 9'd0) ? MOD_LAST : ymod - 9'd1;
        end
      end
    end
  end

endmodule

>>> hdl/calendar_date_stepper_core.sv
// Gregorian date counter. Raise start with a request word while busy is low; the
// block then holds busy until the result word appears on result for exactly one
// cycle with done high. The receiver cannot stall, so capture result whenever
// done is high. A step forward or back moves the date through the date unit
// one day per cycle for step_count days after the accepting edge, then reports;
// cmd 3 or a zero count reports without stepping. A load first runs the
// reciprocal-multiply year-mod-400 unit that feeds the leap-year test, then
// loads the date and then reports.
`include "calendar_date_stepper_core_defines.svh"

module calendar_date_stepper_core #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cds_pkg::cds_request_t request,
  output logic                  done,
  output cds_pkg::cds_result_t  result
);
  import cds_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REM  = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;

  logic [1:0]            state;
  logic [1:0]            cmd_q;
  logic [COUNT_BITS-1:0] cnt;
  logic [4:0]            ld_day;
  logic [3:0]            ld_month;
  logic [YEAR_BITS-1:0]  ld_year;
  logic                  accept;
  logic                  rem_start;
  logic                  rem_done;
  logic [8:0]            rem;
  cds_date_ctrl_t        ctrl;
  logic [4:0]            day;
  logic [3:0]            month;
  logic [YEAR_BITS-1:0]  year;
  logic [31:0]           year_ext;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign rem_start = accept && (request.cmd == CMD_LOAD);
  assign year_ext  = 32'(year);

  always_comb begin
    ctrl.load = (state == S_REM) && rem_done;
    ctrl.fwd  = (state == S_STEP) && (cnt != '0) && (cmd_q == CMD_FWD);
    ctrl.back = (state == S_STEP) && (cnt != '0) && (cmd_q == CMD_BACK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (request.cmd == CMD_LOAD) begin
              state <= S_REM;
            end else begin
              state <= S_STEP;
              cnt   <= (request.cmd == CMD_NONE) ? '0 : COUNT_BITS'(request.step_count);
            end
          end
        end
        S_REM: begin
          if (rem_done) begin
            state <= S_STEP;
            cnt   <= '0;
          end
        end
        S_STEP: begin
          if (cnt == '0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - COUNT_BITS'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= request.cmd;
      ld_day   <= request.new_day;
      ld_month <= request.new_month;
      ld_year  <= YEAR_BITS'(request.new_year);
    end
    if ((state == S_STEP) && (cnt == '0)) begin
      result.cur_day   <= day;
      result.cur_month <= month;
      result.cur_year  <= year_ext[15:0];
    end
  end

  cds_rem400 #(
    .YEAR_BITS(YEAR_BITS)
  ) u_rem (
    .clk  (clk),
    .rst  (rst),
    .start(rem_start),
    .value(YEAR_BITS'(request.new_year)),
    .done (rem_done),
    .rem  (rem)
  );

  cds_date_unit #(
    .YEAR_BITS(YEAR_BITS)
  ) u_date (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .ld_day  (ld_day),
    .ld_month(ld_month),
    .ld_year (ld_year),
    .ld_mod  (rem),
    .day     (day),
    .month   (month),
    .year    (year)
  );

  `CDS_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result word while busy")
  `CDS_ASSERT(a_accept_busy, clk, rst, accept |=> busy, "accepted word did not start work")
  `CDS_ASSERT(a_month_range, clk, rst, done |-> (result.cur_month <= 4'(MONTHS)), "month out of range")
  `CDS_ASSERT(a_month_zero, clk, rst, done && (result.cur_month == 4'd0) |-> (result.cur_day == 5'd0), "day set with no month")
  `CDS_ASSERT(a_rem_in_load, clk, rst, rem_done |-> (state == S_REM), "year remainder outside a load")

endmodule
